// File: rtl/core/lz77td_pkg.sv
package lz77td_pkg;

  // Window and token field sizes.
  localparam int OFFSET_BITS = 12;
  localparam int LENGTH_BITS = 6;
  localparam int BYTE_BITS   = 8;
  localparam int HIST_DEPTH  = 1 << OFFSET_BITS;
  localparam int FILL_BITS   = OFFSET_BITS + 1;

  typedef logic [OFFSET_BITS-1:0] hist_addr_t;
  typedef logic [BYTE_BITS-1:0]   byte_t;

  // One input word: a token.
  typedef struct packed {
    logic                   start_stream;
    logic [OFFSET_BITS-1:0] match_offset;
    logic [LENGTH_BITS-1:0] match_length;
    byte_t                  literal_byte;
  } in_word_t;

  // One output word: a decoded byte.
  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
    logic  bad_offset;
  } out_word_t;

  // History memory write port.
  typedef struct packed {
    logic       en;
    hist_addr_t addr;
    byte_t      data;
  } hist_wr_t;

  // History memory read port.
  typedef struct packed {
    logic       en;
    hist_addr_t addr;
  } hist_rd_t;

endpackage

// File: rtl/core/lz77td_hist_ram.sv
module lz77td_hist_ram
  import lz77td_pkg::*;
(
  input  logic     clk,
  input  hist_wr_t wr,
  input  hist_rd_t rd,
  output byte_t    rd_data
);

  // History window storage; contents are undefined until written.
  byte_t mem [HIST_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: rtl/core/lz77_token_decoder.sv
// Literal and bad-offset tokens: the output word is valid in the cycle after the token is taken.
// Copy tokens of length L: each byte is read from history, then written back and registered as output,
// one byte per cycle unless out_stall; the read-then-write loop stalls the input until the last write.
// Literal and bad-offset tokens can be taken every cycle while the output side keeps up.
// Synchronous active-low reset clears the write pointer, fill count and all handshake state.
// History memory contents are not cleared; the offset check keeps reads within written bytes.
module lz77_token_decoder
  import lz77td_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(HIST_DEPTH);

  // Stream state.
  hist_addr_t             wp_r, wp_nxt;
  logic [FILL_BITS-1:0]   fill_r, fill_nxt;

  // Copy engine state.
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  hist_addr_t             rd_addr_r, rd_addr_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   rd_last_r, rd_last_nxt;
  logic                   fwd_r, fwd_nxt;
  byte_t                  fwd_byte_r, fwd_byte_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  logic                   in_fire;
  logic                   out_free;
  logic                   busy;
  logic                   is_lit;
  logic                   is_bad;
  logic [FILL_BITS-1:0]   fill_eff;
  logic [FILL_BITS-1:0]   fill_base;
  logic                   rd_issue;
  logic                   cp_write;
  byte_t                  cp_byte;
  byte_t                  ram_q;
  hist_wr_t               hist_wr;
  hist_rd_t               hist_rd;

  lz77td_hist_ram u_hist (
    .clk     (clk),
    .wr      (hist_wr),
    .rd      (hist_rd),
    .rd_data (ram_q)
  );

  // Handshake and token decode.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    busy     = (rem_r != '0) || rd_pend_r;
    in_stall = busy || !out_free;
    in_fire  = in_valid && !in_stall;
    fill_eff = in_word.start_stream ? '0 : fill_r;
    is_lit   = (in_word.match_offset == '0) || (in_word.match_length == '0);
    is_bad   = !is_lit && ({1'b0, in_word.match_offset} > fill_eff);
  end

  // Copy pipeline: a read goes out while the previous byte is written back.
  // When a read hits the entry being written this cycle, the written byte is forwarded.
  always_comb begin
    rd_issue = (rem_r != '0) && (!rd_pend_r || out_free);
    cp_write = rd_pend_r && out_free;
    cp_byte  = fwd_r ? fwd_byte_r : ram_q;

    hist_rd.en   = rd_issue;
    hist_rd.addr = rd_addr_r;

    hist_wr.en   = (in_fire && is_lit) || cp_write;
    hist_wr.addr = wp_r;
    hist_wr.data = cp_write ? cp_byte : in_word.literal_byte;
  end

  // Next-state logic.
  always_comb begin
    wp_nxt       = hist_wr.en ? wp_r + 1'b1 : wp_r;
    fill_base    = in_fire ? fill_eff : fill_r;
    fill_nxt     = (hist_wr.en && (fill_base != FILL_MAX)) ? fill_base + 1'b1 : fill_base;

    rem_nxt      = rem_r;
    rd_addr_nxt  = rd_addr_r;
    if (in_fire && !is_lit && !is_bad) begin
      rem_nxt     = in_word.match_length;
      rd_addr_nxt = wp_r - in_word.match_offset;
    end else if (rd_issue) begin
      rem_nxt     = rem_r - 1'b1;
      rd_addr_nxt = rd_addr_r + 1'b1;
    end

    rd_pend_nxt  = rd_issue ? 1'b1 : (cp_write ? 1'b0 : rd_pend_r);
    rd_last_nxt  = rd_issue ? (rem_r == LENGTH_BITS'(1)) : rd_last_r;
    fwd_nxt      = rd_issue ? (cp_write && (rd_addr_r == wp_r)) : fwd_r;
    fwd_byte_nxt = rd_issue ? cp_byte : fwd_byte_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (in_fire && is_lit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '{out_byte: in_word.literal_byte, run_last: 1'b1, bad_offset: 1'b0};
    end else if (in_fire && is_bad) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '{out_byte: '0, run_last: 1'b1, bad_offset: 1'b1};
    end else if (cp_write) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '{out_byte: cp_byte, run_last: rd_last_r, bad_offset: 1'b0};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fill_r      <= '0;
      rem_r       <= '0;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      rd_pend_r   <= rd_pend_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    rd_last_r  <= rd_last_nxt;
    fwd_byte_r <= fwd_byte_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/core/lz77td_checker.sv
module lz77td_checker
  import lz77td_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // An error word carries a zero byte and ends its token.
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.bad_offset |-> out_word.run_last && (out_word.out_byte == '0))
    else $error("malformed error word");

  // A literal token shows its byte in the next cycle.
  a_lit_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    ((in_word.match_offset == '0) || (in_word.match_length == '0))
    |=> out_valid && out_word.run_last && !out_word.bad_offset &&
        (out_word.out_byte == $past(in_word.literal_byte)))
    else $error("literal token not echoed");

  // A match token either reports an error at once or holds the input while copying.
  a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_word.match_offset != '0) && (in_word.match_length != '0)
    |=> (out_valid && out_word.bad_offset) || in_stall)
    else $error("match token neither copied nor rejected");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lz77_token_decoder lz77td_checker u_lz77td_checker (.*);
